### rtl/spq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

	localparam int DATA_W = 32;
	localparam int CNT_W  = 4;
	localparam int CAP_W  = 4;

	// capacity after reset
	localparam logic [CAP_W-1:0] CAP_RESET = 4'd8;

	// operation codes
	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_DELETE = 1'b1;

	// result status codes
	typedef enum logic [1:0] {
		STAT_DONE  = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2
	} status_t;

	// controller states
	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	// controller to datapath commands
	typedef struct packed {
		logic load;
		logic exec;
	} cmd_t;

endpackage : spq_pkg
`default_nettype wire

### rtl/spq_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spq_req_if
// Request channel: one operation and its value per item.
// ----------------------------------------------------------------------------
interface spq_req_if
	import spq_pkg::*;
();
	logic              valid;
	logic              ready;
	logic              operation;
	logic [DATA_W-1:0] new_value;

	modport source (output valid, output operation, output new_value, input ready);
	modport sink   (input valid, input operation, input new_value, output ready);
endinterface : spq_req_if
`default_nettype wire

### rtl/spq_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spq_rsp_if
// Response channel: status, removed value and occupancy per item.
// ----------------------------------------------------------------------------
interface spq_rsp_if
	import spq_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [1:0]        status;
	logic [DATA_W-1:0] removed_value;
	logic [CNT_W-1:0]  occupancy;

	modport source (output valid, output status, output removed_value, output occupancy,
		input ready);
	modport sink   (input valid, input status, input removed_value, input occupancy,
		output ready);
endinterface : spq_rsp_if
`default_nettype wire

### rtl/spq_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spq_ctrl
// Sequencer: latches a request, then runs it once the result slot is free.
// ----------------------------------------------------------------------------
module spq_ctrl
	import spq_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_ready,
	output logic      rsp_valid,
	input  wire logic rsp_ready,
	output cmd_t      cmd
);

	state_t state_q, state_d;
	logic   rsp_valid_q;
	logic   slot_free;

	// result register can take a new item
	assign slot_free = !rsp_valid_q || rsp_ready;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) state_d = S_EXEC;
			end
			S_EXEC: begin
				if (slot_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		req_ready = 1'b0;
		cmd       = '0;
		case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				cmd.load  = req_valid;
			end
			S_EXEC: begin
				cmd.exec = slot_free;
			end
			default: begin
				req_ready = 1'b0;
			end
		endcase
	end

	// state and result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.exec) rsp_valid_q <= 1'b1;
			else if (rsp_ready) rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = rsp_valid_q;

endmodule : spq_ctrl
`default_nettype wire

### rtl/spq_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spq_datapath
// Row of sorted entry cells with per-cell compare, plus count, capacity
// and the result register.
// ----------------------------------------------------------------------------
module spq_datapath
	import spq_pkg::*;
#(
	parameter int DEPTH = 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cmd_t              cmd,
	input  wire logic              cfg_we,
	input  wire logic [CAP_W-1:0]  cfg_wdata,
	input  wire logic              operation,
	input  wire logic [DATA_W-1:0] new_value,
	output logic [1:0]             status,
	output logic [DATA_W-1:0]      removed_value,
	output logic [CNT_W-1:0]       occupancy
);

	// largest count the 4-bit capacity and the depth allow
	localparam int CAP_MAX = (DEPTH < 15) ? DEPTH : 15;

	logic signed [DATA_W-1:0] entry_q [DEPTH];
	logic signed [DATA_W-1:0] val_q;
	logic                     op_q;
	logic [CNT_W-1:0]         count_q;
	logic [CAP_W-1:0]         cap_q;
	logic [CAP_W-1:0]         limit;
	logic                     full;
	logic                     empty;
	logic [DEPTH-1:0]         keep;

	status_t                  res_status_q;
	logic [DATA_W-1:0]        res_removed_q;
	logic [CNT_W-1:0]         res_count_q;

	// effective limit saturates at the depth
	assign limit = (cap_q > CAP_W'(CAP_MAX)) ? CAP_W'(CAP_MAX) : cap_q;
	assign full  = (count_q >= limit);
	assign empty = (count_q == '0);

	// per cell: live and not greater than the new value stays in place
	for (genvar i = 0; i < DEPTH; i++) begin : g_keep
		if (i < 16) begin : g_live
			assign keep[i] = (CNT_W'(i) < count_q) && !(entry_q[i] > val_q);
		end else begin : g_dead
			assign keep[i] = 1'b0;
		end
	end

	// entry cells: insert shifts up behind the slot, delete shifts down
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		always_ff @(posedge clk) begin
			if (cmd.exec) begin
				if (op_q == OP_INSERT) begin
					if (!full && !keep[i]) begin
						if (i == 0) entry_q[i] <= val_q;
						else if (keep[(i > 0) ? i - 1 : 0]) entry_q[i] <= val_q;
						else entry_q[i] <= entry_q[(i > 0) ? i - 1 : 0];
					end
				end else begin
					if (!empty && (i < DEPTH - 1)) begin
						entry_q[i] <= entry_q[(i < DEPTH - 1) ? i + 1 : i];
					end
				end
			end
		end
	end

	// request latch
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= operation;
			val_q <= new_value;
		end
	end

	// capacity register and live count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q   <= CAP_RESET;
			count_q <= '0;
		end else begin
			if (cfg_we) cap_q <= cfg_wdata;
			if (cmd.exec) begin
				if (op_q == OP_INSERT) begin
					if (!full) count_q <= count_q + CNT_W'(1);
				end else begin
					if (!empty) count_q <= count_q - CNT_W'(1);
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			res_removed_q <= '0;
			if (op_q == OP_INSERT) begin
				if (full) begin
					res_status_q <= STAT_FULL;
					res_count_q  <= count_q;
				end else begin
					res_status_q <= STAT_DONE;
					res_count_q  <= count_q + CNT_W'(1);
				end
			end else begin
				if (empty) begin
					res_status_q <= STAT_EMPTY;
					res_count_q  <= count_q;
				end else begin
					res_status_q  <= STAT_DONE;
					res_removed_q <= entry_q[0];
					res_count_q   <= count_q - CNT_W'(1);
				end
			end
		end
	end

	assign status        = res_status_q;
	assign removed_value = res_removed_q;
	assign occupancy     = res_count_q;

endmodule : spq_datapath
`default_nettype wire

### rtl/sorted_priority_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Ascending queue of signed values: insert after equals, delete smallest.
// ----------------------------------------------------------------------------
//  channel  dir  handshake        payload
//  req      in   valid / ready    operation, new_value
//  rsp      out  valid / ready    status, removed_value, occupancy
//  cfg      in   cfg_we           cfg_wdata (capacity)
//
// Each item: S_IDLE latches the request, then S_EXEC waits for a free result
// register; all entry cells compare and shift in parallel as the result loads.
// Reset clears the count and sets capacity to 8; entries are not cleared.
// A result waits in its register until taken; the next item is accepted
// meanwhile and runs as soon as the result register frees.
// ----------------------------------------------------------------------------
module sorted_priority_queue
	import spq_pkg::*;
#(
	parameter int DEPTH = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic [CAP_W-1:0] cfg_wdata,
	spq_req_if.sink               req,
	spq_rsp_if.source             rsp
);

	cmd_t cmd;

	// sequencer
	spq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.cmd       (cmd)
	);

	// cells, count and result register
	spq_datapath #(
		.DEPTH (DEPTH)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.operation     (req.operation),
		.new_value     (req.new_value),
		.status        (rsp.status),
		.removed_value (rsp.removed_value),
		.occupancy     (rsp.occupancy)
	);

endmodule : sorted_priority_queue
`default_nettype wire
